// ===== src/argt_pkg.sv =====
// Shared types, constants and microcode for the anemometer rain gust tracker.
package argt_pkg;

    localparam int RING_DEPTH_DEF = 20;
    localparam logic [15:0] DEBOUNCE_RST = 16'd10;
    localparam logic [15:0] GUST_INTERVAL_RST = 16'd3000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUST_INTERVAL = 2'd1;

    localparam logic [2:0] OP_WIND = 3'd0;
    localparam logic [2:0] OP_RAIN = 3'd1;
    localparam logic [2:0] OP_SAMPLE = 3'd2;
    localparam logic [2:0] OP_GUST_RST = 3'd3;
    localparam logic [2:0] OP_FULL_RST = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [31:0] wind_pulses;
        logic [31:0] rain_pulses;
        logic [31:0] shortest_gap_ms;
        logic [31:0] gust_max_revs;
        logic        sample_taken;
    } out_word_t;

    // Microprogram addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] UA_CLEAR    = 4'd0;
    localparam logic [UPC_W-1:0] UA_IDLE     = 4'd1;
    localparam logic [UPC_W-1:0] UA_WIND     = 4'd2;
    localparam logic [UPC_W-1:0] UA_RAIN     = 4'd3;
    localparam logic [UPC_W-1:0] UA_GUST_RST = 4'd4;
    localparam logic [UPC_W-1:0] UA_FULL_RST = 4'd5;
    localparam logic [UPC_W-1:0] UA_FULL_CLR = 4'd6;
    localparam logic [UPC_W-1:0] UA_SAMPLE   = 4'd7;
    localparam logic [UPC_W-1:0] UA_SCAN_RD  = 4'd8;
    localparam logic [UPC_W-1:0] UA_SCAN     = 4'd9;
    localparam logic [UPC_W-1:0] UA_EMIT     = 4'd10;

    typedef enum logic [3:0] {
        U_NOP,
        U_FETCH,
        U_WIND,
        U_RAIN,
        U_GUST_RST,
        U_FULL_RST,
        U_CLR_WR,
        U_SAMPLE,
        U_SCAN_RD,
        U_SCAN_CMP,
        U_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT,       // fall through
        C_JUMP,       // go to target
        C_DISPATCH,   // wait for a word, then branch on opcode
        C_IF_TAKE,    // fall through on a sample, else go to target
        C_LOOP_LAST,  // repeat until index reaches the last entry
        C_LOOP_END,   // repeat until index passes the last entry
        C_WAIT_OUT    // repeat until output slot is free, then go to target
    } ucond_t;

    typedef struct packed {
        uop_t             action;
        ucond_t           cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
        uword_t w;
        case (pc)
            UA_CLEAR:    w = '{U_CLR_WR,   C_LOOP_LAST, UA_IDLE};
            UA_IDLE:     w = '{U_FETCH,    C_DISPATCH,  UA_IDLE};
            UA_WIND:     w = '{U_WIND,     C_JUMP,      UA_EMIT};
            UA_RAIN:     w = '{U_RAIN,     C_JUMP,      UA_EMIT};
            UA_GUST_RST: w = '{U_GUST_RST, C_JUMP,      UA_EMIT};
            UA_FULL_RST: w = '{U_FULL_RST, C_NEXT,      UA_FULL_CLR};
            UA_FULL_CLR: w = '{U_CLR_WR,   C_LOOP_LAST, UA_EMIT};
            UA_SAMPLE:   w = '{U_SAMPLE,   C_IF_TAKE,   UA_EMIT};
            UA_SCAN_RD:  w = '{U_SCAN_RD,  C_NEXT,      UA_SCAN};
            UA_SCAN:     w = '{U_SCAN_CMP, C_LOOP_END,  UA_EMIT};
            UA_EMIT:     w = '{U_EMIT,     C_WAIT_OUT,  UA_IDLE};
            default:     w = '{U_NOP,      C_JUMP,      UA_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] dispatch(input logic [2:0] op);
        logic [UPC_W-1:0] a;
        case (op)
            OP_WIND:     a = UA_WIND;
            OP_RAIN:     a = UA_RAIN;
            OP_SAMPLE:   a = UA_SAMPLE;
            OP_GUST_RST: a = UA_GUST_RST;
            OP_FULL_RST: a = UA_FULL_RST;
            default:     a = UA_EMIT;
        endcase
        return a;
    endfunction

endpackage

// ===== src/argt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module argt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/anemometer_rain_gust_tracker_top.sv =====
// Top level of the anemometer rain gust tracker: microcoded sequencer and datapath.
//
// Input words (s_valid/s_ready, s_data) carry an opcode and a millisecond
// timestamp: wind pulse, rain pulse, gust sample check, gust reset or full
// reset. Each input word yields exactly one result word on m_valid/m_ready,
// m_data, holding both pulse counts, the shortest wind interval, the largest
// entry of the gust ring and whether this word stored a new ring entry.
// Registers (debounce, gust interval) are written on cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. The user must write them
// only while the block is idle; the block itself does not enforce this.
// Pulses, gust resets and samples that are not due take one action step before
// the emit step; unused opcodes go straight to emit. A taken sample makes one
// write and one read setup, then rescans the ring through the RAM read port,
// one entry per cycle; a full reset sweeps zeros into the ring one entry per
// cycle. A new word is taken in the cycle after the result is loaded. After
// aresetn the sequencer clears the ring with s_ready low. A stalled receiver
// holds the result register; the next word may still be accepted, but its
// result waits for the slot and s_ready stays low meanwhile.
module anemometer_rain_gust_tracker_top #(
    parameter int RING_DEPTH = argt_pkg::RING_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  argt_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output argt_pkg::out_word_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [argt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                     cfg_data
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int IW = $clog2(RING_DEPTH + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(RING_DEPTH - 1);
    localparam logic [IW-1:0] IDX_END = IW'(RING_DEPTH);
    localparam logic [AW-1:0] POS_LAST = AW'(RING_DEPTH - 1);

    logic [argt_pkg::UPC_W-1:0] upc_reg, upc_next;
    logic [15:0] debounce_reg, debounce_next;
    logic [15:0] gust_int_reg, gust_int_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] last_wind_reg, last_wind_next;
    logic [31:0] last_rain_reg, last_rain_next;
    logic [31:0] last_sample_reg, last_sample_next;
    logic [31:0] wind_cnt_reg, wind_cnt_next;
    logic [31:0] rain_cnt_reg, rain_cnt_next;
    logic [31:0] min_gap_reg, min_gap_next;
    logic [31:0] prev_wind_reg, prev_wind_next;
    logic [31:0] gust_max_reg, gust_max_next;
    logic [AW-1:0] ring_pos_reg, ring_pos_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic        taken_reg, taken_next;
    logic        m_valid_reg, m_valid_next;
    argt_pkg::out_word_t m_data_reg, m_data_next;

    argt_pkg::uword_t uw;
    logic [31:0] wind_delta, rain_delta, sample_delta;
    logic        wind_ok, rain_ok, sample_due, slot_free, in_fire;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    assign uw = argt_pkg::ucode(upc_reg);
    assign s_ready = (upc_reg == argt_pkg::UA_IDLE);
    assign in_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;

    assign wind_delta = now_reg - last_wind_reg;
    assign rain_delta = now_reg - last_rain_reg;
    assign sample_delta = now_reg - last_sample_reg;
    assign wind_ok = wind_delta >= {16'd0, debounce_reg};
    assign rain_ok = rain_delta >= {16'd0, debounce_reg};
    assign sample_due = sample_delta >= {16'd0, gust_int_reg};

    argt_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // datapath actions
    always_comb begin
        now_next = now_reg;
        last_wind_next = last_wind_reg;
        last_rain_next = last_rain_reg;
        last_sample_next = last_sample_reg;
        wind_cnt_next = wind_cnt_reg;
        rain_cnt_next = rain_cnt_reg;
        min_gap_next = min_gap_reg;
        prev_wind_next = prev_wind_reg;
        gust_max_next = gust_max_reg;
        ring_pos_next = ring_pos_reg;
        idx_next = idx_reg;
        taken_next = taken_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;
        ram_we = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = '0;
        case (uw.action)
            argt_pkg::U_FETCH: begin
                if (in_fire) begin
                    now_next = s_data.now_ms;
                    taken_next = 1'b0;
                end
            end
            argt_pkg::U_WIND: begin
                if (wind_ok) begin
                    if (wind_delta < min_gap_reg) begin
                        min_gap_next = wind_delta;
                    end
                    wind_cnt_next = wind_cnt_reg + 32'd1;
                    last_wind_next = now_reg;
                end
            end
            argt_pkg::U_RAIN: begin
                if (rain_ok) begin
                    rain_cnt_next = rain_cnt_reg + 32'd1;
                    last_rain_next = now_reg;
                end
            end
            argt_pkg::U_GUST_RST: begin
                ring_pos_next = '0;
                prev_wind_next = '0;
            end
            argt_pkg::U_FULL_RST: begin
                wind_cnt_next = '0;
                rain_cnt_next = '0;
                min_gap_next = argt_pkg::ALL_ONES;
                prev_wind_next = '0;
                ring_pos_next = '0;
                gust_max_next = '0;
                idx_next = '0;
            end
            argt_pkg::U_CLR_WR: begin
                ram_we = 1'b1;
                idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + IW'(1);
            end
            argt_pkg::U_SAMPLE: begin
                if (sample_due) begin
                    ram_we = 1'b1;
                    ram_waddr = ring_pos_reg;
                    ram_wdata = wind_cnt_reg - prev_wind_reg;
                    prev_wind_next = wind_cnt_reg;
                    last_sample_next = now_reg;
                    ring_pos_next = (ring_pos_reg == POS_LAST) ? '0 : ring_pos_reg + AW'(1);
                    taken_next = 1'b1;
                    gust_max_next = '0;
                    idx_next = '0;
                end
            end
            argt_pkg::U_SCAN_RD: begin
                idx_next = idx_reg + IW'(1);
            end
            argt_pkg::U_SCAN_CMP: begin
                // rdata holds the entry read on the previous cycle
                if (ram_rdata > gust_max_reg) begin
                    gust_max_next = ram_rdata;
                end
                if (idx_reg != IDX_END) begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            argt_pkg::U_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.wind_pulses = wind_cnt_reg;
                    m_data_next.rain_pulses = rain_cnt_reg;
                    m_data_next.shortest_gap_ms = min_gap_reg;
                    m_data_next.gust_max_revs = gust_max_reg;
                    m_data_next.sample_taken = taken_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        upc_next = upc_reg + argt_pkg::UPC_W'(1);
        case (uw.cond)
            argt_pkg::C_NEXT: begin
                upc_next = upc_reg + argt_pkg::UPC_W'(1);
            end
            argt_pkg::C_JUMP: begin
                upc_next = uw.target;
            end
            argt_pkg::C_DISPATCH: begin
                upc_next = in_fire ? argt_pkg::dispatch(s_data.opcode) : upc_reg;
            end
            argt_pkg::C_IF_TAKE: begin
                upc_next = sample_due ? upc_reg + argt_pkg::UPC_W'(1) : uw.target;
            end
            argt_pkg::C_LOOP_LAST: begin
                upc_next = (idx_reg == IDX_LAST) ? uw.target : upc_reg;
            end
            argt_pkg::C_LOOP_END: begin
                upc_next = (idx_reg == IDX_END) ? uw.target : upc_reg;
            end
            argt_pkg::C_WAIT_OUT: begin
                upc_next = slot_free ? uw.target : upc_reg;
            end
            default: begin
                upc_next = argt_pkg::UA_IDLE;
            end
        endcase
    end

    always_comb begin
        debounce_next = debounce_reg;
        gust_int_next = gust_int_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                argt_pkg::CFG_DEBOUNCE:      debounce_next = cfg_data;
                argt_pkg::CFG_GUST_INTERVAL: gust_int_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= argt_pkg::UA_CLEAR;
            debounce_reg <= argt_pkg::DEBOUNCE_RST;
            gust_int_reg <= argt_pkg::GUST_INTERVAL_RST;
            last_wind_reg <= '0;
            last_rain_reg <= '0;
            last_sample_reg <= '0;
            wind_cnt_reg <= '0;
            rain_cnt_reg <= '0;
            min_gap_reg <= argt_pkg::ALL_ONES;
            prev_wind_reg <= '0;
            gust_max_reg <= '0;
            ring_pos_reg <= '0;
            idx_reg <= '0;
            taken_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            debounce_reg <= debounce_next;
            gust_int_reg <= gust_int_next;
            last_wind_reg <= last_wind_next;
            last_rain_reg <= last_rain_next;
            last_sample_reg <= last_sample_next;
            wind_cnt_reg <= wind_cnt_next;
            rain_cnt_reg <= rain_cnt_next;
            min_gap_reg <= min_gap_next;
            prev_wind_reg <= prev_wind_next;
            gust_max_reg <= gust_max_next;
            ring_pos_reg <= ring_pos_next;
            idx_reg <= idx_next;
            taken_reg <= taken_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg <= now_next;
        m_data_reg <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_END)
        else $error("ring index ran past the end");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_pos_reg <= POS_LAST)
        else $error("ring position out of range");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(upc_reg == argt_pkg::UA_EMIT))
        else $error("result raised outside the emit step");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");
`endif

endmodule

// ===== tb/tb_anemometer_rain_gust_tracker_top.sv =====
// Testbench for the anemometer rain gust tracker: random events checked against a predictor.
`timescale 1ns / 1ps

module tb_anemometer_rain_gust_tracker_top;

    localparam int RING = argt_pkg::RING_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam logic [argt_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [argt_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    argt_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    argt_pkg::out_word_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [argt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    anemometer_rain_gust_tracker_top DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state
    logic [15:0] debounce_cfg = argt_pkg::DEBOUNCE_RST;
    logic [15:0] gust_cfg = argt_pkg::GUST_INTERVAL_RST;
    logic [31:0] last_wind_at = '0;
    logic [31:0] last_rain_at = '0;
    logic [31:0] last_sample_at = '0;
    logic [31:0] wind_total = '0;
    logic [31:0] rain_total = '0;
    logic [31:0] min_wind_gap = argt_pkg::ALL_ONES;
    logic [31:0] wind_at_sample = '0;
    logic [4:0] ring_slot = '0;
    logic [31:0] gust_ring [RING];

    argt_pkg::in_word_t pending_events[$];
    argt_pkg::out_word_t expected_reports[$];
    int errors = 0;
    int cycles = 0;
    int s_idle_pct = 22;
    int m_idle_pct = 22;
    bit hold_request = 1'b0;
    int hold_left = 0;
    logic in_accepted = 1'b0;
    logic [31:0] gen_ms = '0;

    function automatic void clear_counts();
        wind_total = '0;
        rain_total = '0;
        min_wind_gap = argt_pkg::ALL_ONES;
        wind_at_sample = '0;
        ring_slot = '0;
        for (int k = 0; k < RING; k++) gust_ring[k] = '0;
    endfunction

    function automatic argt_pkg::out_word_t predict_event(input argt_pkg::in_word_t w);
        argt_pkg::out_word_t r;
        logic [31:0] gap;
        logic [31:0] best;
        r.sample_taken = 1'b0;
        case (w.opcode)
            argt_pkg::OP_WIND: begin
                gap = w.now_ms - last_wind_at;
                if (gap >= {16'd0, debounce_cfg}) begin
                    if (gap < min_wind_gap) min_wind_gap = gap;
                    wind_total = wind_total + 32'd1;
                    last_wind_at = w.now_ms;
                end
            end
            argt_pkg::OP_RAIN: begin
                gap = w.now_ms - last_rain_at;
                if (gap >= {16'd0, debounce_cfg}) begin
                    rain_total = rain_total + 32'd1;
                    last_rain_at = w.now_ms;
                end
            end
            argt_pkg::OP_SAMPLE: begin
                gap = w.now_ms - last_sample_at;
                if (gap >= {16'd0, gust_cfg}) begin
                    last_sample_at = w.now_ms;
                    gust_ring[ring_slot] = wind_total - wind_at_sample;
                    wind_at_sample = wind_total;
                    ring_slot = (ring_slot == RING - 1) ? 5'd0 : ring_slot + 5'd1;
                    r.sample_taken = 1'b1;
                end
            end
            argt_pkg::OP_GUST_RST: begin
                ring_slot = '0;
                wind_at_sample = '0;
            end
            argt_pkg::OP_FULL_RST: clear_counts();
            default: ;
        endcase
        best = gust_ring[0];
        for (int k = 1; k < RING; k++) if (gust_ring[k] > best) best = gust_ring[k];
        r.wind_pulses = wind_total;
        r.rain_pulses = rain_total;
        r.shortest_gap_ms = min_wind_gap;
        r.gust_max_revs = best;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Input driver: advance to the next pending word once the current one is taken
    always @(negedge aclk) begin
        if (!s_valid || in_accepted) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                s_data <= pending_events.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // Monitor: predict on input accept, compare on result accept
    always @(posedge aclk) begin
        argt_pkg::out_word_t want;
        in_accepted <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) expected_reports.push_back(predict_event(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %h", $time, m_data);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                check_field("wind_pulses", want.wind_pulses, m_data.wind_pulses);
                check_field("rain_pulses", want.rain_pulses, m_data.rain_pulses);
                check_field("shortest_gap_ms", want.shortest_gap_ms, m_data.shortest_gap_ms);
                check_field("gust_max_revs", want.gust_max_revs, m_data.gust_max_revs);
                check_field("sample_taken", {31'd0, want.sample_taken},
                            {31'd0, m_data.sample_taken});
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_event(input logic [2:0] op, input logic [31:0] ms);
        argt_pkg::in_word_t w;
        w.opcode = op;
        w.now_ms = ms;
        pending_events.push_back(w);
    endtask

    task automatic write_reg(input logic [argt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            argt_pkg::CFG_DEBOUNCE: debounce_cfg = val;
            argt_pkg::CFG_GUST_INTERVAL: gust_cfg = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly pulses and sample checks on an advancing clock, a few resets and noise
    task automatic stream_events(input int count, input int step_max);
        int pick;
        logic [2:0] op;
        for (int n = 0; n < count; n++) begin
            gen_ms = gen_ms + $urandom_range(0, step_max);
            pick = $urandom_range(99);
            if (pick < 40) op = argt_pkg::OP_WIND;
            else if (pick < 60) op = argt_pkg::OP_RAIN;
            else if (pick < 89) op = argt_pkg::OP_SAMPLE;
            else if (pick < 91) op = argt_pkg::OP_GUST_RST;
            else if (pick < 92) op = argt_pkg::OP_FULL_RST;
            else if (pick < 95) op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else begin
                op = 3'($urandom_range(0, 7));
                gen_ms = $urandom();
            end
            send_event(op, gen_ms);
        end
    endtask

    task automatic run_phase(input logic [15:0] deb, input logic [15:0] gust,
                             input int step_max, input int count, input bit hold);
        write_reg(argt_pkg::CFG_DEBOUNCE, deb);
        write_reg(argt_pkg::CFG_GUST_INTERVAL, gust);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  16'($urandom_range(0, 65535)));
        @(posedge aclk);
        if (hold) hold_request = 1'b1;
        stream_events(count, step_max);
        wait_drained();
    endtask

    initial begin
        for (int k = 0; k < RING; k++) gust_ring[k] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed events with the reset register values
        send_event(argt_pkg::OP_WIND, 32'd0);
        send_event(argt_pkg::OP_WIND, 32'd9);
        send_event(argt_pkg::OP_WIND, 32'd10);
        send_event(argt_pkg::OP_WIND, 32'd19);
        send_event(argt_pkg::OP_WIND, 32'd30);
        send_event(argt_pkg::OP_RAIN, 32'd9);
        send_event(argt_pkg::OP_RAIN, 32'd10);
        send_event(argt_pkg::OP_SAMPLE, 32'd2999);
        send_event(argt_pkg::OP_SAMPLE, 32'd3000);
        send_event(argt_pkg::OP_WIND, 32'd3010);
        send_event(argt_pkg::OP_WIND, 32'd3020);
        send_event(argt_pkg::OP_SAMPLE, 32'd6000);
        send_event(argt_pkg::OP_GUST_RST, 32'd6001);
        send_event(argt_pkg::OP_SAMPLE, 32'd9000);
        send_event(OP_SPARE_FIRST, 32'd9001);
        send_event(OP_SPARE_MID, 32'hAAAA_5555);
        send_event(OP_SPARE_LAST, 32'h5555_AAAA);
        send_event(argt_pkg::OP_FULL_RST, 32'd9002);
        send_event(argt_pkg::OP_WIND, 32'hFFFF_FFFF);
        send_event(argt_pkg::OP_WIND, 32'd9);
        send_event(argt_pkg::OP_RAIN, 32'hFFFF_FFFF);
        send_event(argt_pkg::OP_SAMPLE, 32'hFFFF_FFFF);
        send_event(argt_pkg::OP_SAMPLE, 32'd0);
        wait_drained();

        run_phase(16'd0, 16'd0, 20, 190, 1'b0);
        gen_ms = 32'hFFF0_0000;
        run_phase(16'hFFFF, 16'hFFFF, 140000, 190, 1'b0);
        run_phase(16'd12, 16'd40, 30, 190, 1'b1);
        s_idle_pct = 0;
        m_idle_pct = 0;
        run_phase(16'd0, 16'd1, 4, 190, 1'b0);
        s_idle_pct = 22;
        m_idle_pct = 22;
        run_phase(16'hFFFF, 16'd0, 70000, 190, 1'b0);
        for (int p = 0; p < 5; p++) begin
            int deb;
            deb = $urandom_range(0, 60);
            run_phase(16'(deb), 16'($urandom_range(1, 400)), 2 * deb + 10, 190, 1'b0);
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/argt_pkg.sv
src/argt_ram.sv
src/anemometer_rain_gust_tracker_top.sv
tb/tb_anemometer_rain_gust_tracker_top.sv
